@@ rtl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types, codes and line layout for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 62;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int LINE_W  = 1 + TAG_W + STAMP_W;

  // line layout: {valid, tag, stamp}
  localparam int LINE_VALID_BIT = LINE_W - 1;
  localparam int LINE_TAG_LSB   = STAMP_W;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_MISS    = 2'd1,
    OUT_EVICT   = 2'd2,
    OUT_IGNORED = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS_USED  = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_t;

endpackage

@@ rtl/sacl_pick.sv @@
// ----------------------------------------------------------------------------
// sacl_pick
// Way lookup for one set: first free or matching way in use, else the LRU
// victim (smallest stamp, lowest way on a tie).
// ----------------------------------------------------------------------------
module sacl_pick
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS = MAX_WAYS_DEF,
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [MAX_WAYS-1:0][LINE_W-1:0] row,
  input  logic [TAG_W-1:0]                tag,
  input  logic [3:0]                      ways_used,
  output outcome_t                        outcome,
  output logic [WAY_W-1:0]                way
);

  logic [MAX_WAYS-1:0] in_use;
  logic                found;
  logic                found_valid;
  logic [WAY_W-1:0]    found_way;
  logic [WAY_W-1:0]    victim;
  logic [STAMP_W-1:0]  oldest;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      // way 0 is always in use, so a zero setting acts as one way
      in_use[i] = (i == 0) || (i < int'(ways_used));
    end
  end

  always_comb begin
    found       = 1'b0;
    found_valid = 1'b0;
    found_way   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!found && in_use[i] &&
          (!row[i][LINE_VALID_BIT] ||
           row[i][LINE_TAG_LSB +: TAG_W] == tag)) begin
        found       = 1'b1;
        found_valid = row[i][LINE_VALID_BIT];
        found_way   = WAY_W'(i);
      end
    end
  end

  always_comb begin
    oldest = row[0][STAMP_W-1:0];
    victim = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && row[i][STAMP_W-1:0] < oldest) begin
        oldest = row[i][STAMP_W-1:0];
        victim = WAY_W'(i);
      end
    end
  end

  always_comb begin
    if (!found) begin
      outcome = OUT_EVICT;
      way     = victim;
    end else if (found_valid) begin
      outcome = OUT_HIT;
      way     = found_way;
    end else begin
      outcome = OUT_MISS;
      way     = found_way;
    end
  end

endmodule

@@ rtl/set_assoc_lru_cache_sim.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Tag-only set-associative cache with LRU replacement and running totals.
// ----------------------------------------------------------------------------
// Each transaction reads its set row from the line memory into a register
// on accept; in the busy state the ways in use are compared, the way is
// picked, the row is written back and the result register is loaded. The
// line memory holds one row per set with every way side by side, so one read
// and at most one write per transaction. A new transaction is taken while an
// earlier result still waits at the output; it only holds in the busy state
// until that result is gone. After reset a clearing pass zeroes the line
// memory, one row a cycle, over all 2**MAX_SET_BITS rows (64 by default);
// in_stall stays high meanwhile and configuration writes are taken as usual.
// Ways not in use keep their contents; new geometry acts on existing lines.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // apb configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // access channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [ADDR_W-1:0]  address,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         outcome,
  output logic               second_hit,
  output logic [CNT_W-1:0]   hits_total,
  output logic [CNT_W-1:0]   misses_total,
  output logic [CNT_W-1:0]   evictions_total
);

  localparam int SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W = MAX_SET_BITS;
  localparam int SB_W  = $clog2(MAX_SET_BITS + 1);
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef logic [MAX_WAYS-1:0][LINE_W-1:0] row_t;

  // configuration registers
  logic [2:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways_used;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   finish;

  logic [SET_W-1:0] clr_idx;

  // address split
  logic [5:0]        blk_eff;
  logic [SB_W-1:0]   sb_eff;
  logic [ADDR_W-1:0] line_addr;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;

  // transaction in flight
  op_t              op_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  row_t mem [SETS];
  row_t rd_row;
  row_t wr_row;
  logic mem_we;

  outcome_t         pick_outcome;
  logic [WAY_W-1:0] pick_way;

  logic [STAMP_W-1:0] stamp_cnt;
  logic [STAMP_W-1:0] stamp_next;
  logic [STAMP_W-1:0] line_stamp;
  logic [1:0]         hit_inc;
  logic               miss_inc;
  logic               evict_inc;
  outcome_t           outcome_next;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, c} + {{(CNT_W-1){1'b0}}, inc};
    return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 3'd1;
      block_bits <= 6'd5;
      ways_used  <= 4'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SET_BITS:   set_bits   <= pwdata[2:0];
        REG_BLOCK_BITS: block_bits <= pwdata[5:0];
        REG_WAYS_USED:  ways_used  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SET_BITS:   prdata = {{(PDATA_W-3){1'b0}}, set_bits};
      REG_BLOCK_BITS: prdata = {{(PDATA_W-6){1'b0}}, block_bits};
      REG_WAYS_USED:  prdata = {{(PDATA_W-4){1'b0}}, ways_used};
      default:        prdata = '0;
    endcase
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = rst || (state != ST_IDLE);
    finish     = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_BUSY;
      end
      ST_BUSY: begin
        if (!(out_valid && out_stall)) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + SET_W'(1);
    end
  end

  // ---------------- address split ----------------
  always_comb begin
    blk_eff   = (block_bits == 6'd0) ? 6'd1 : block_bits;
    line_addr = address >> blk_eff;
    if (set_bits == 3'd0) begin
      sb_eff = SB_W'(1);
    end else if (int'(set_bits) > MAX_SET_BITS) begin
      sb_eff = SB_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SB_W'(set_bits);
    end
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(sb_eff));
    end
    set_in = line_addr[SET_W-1:0] & set_mask;
    tag_in = TAG_W'(line_addr >> sb_eff);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op_t'(operation);
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // ---------------- line memory ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= mem[set_in];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[clr_idx] <= '0;
    end else if (mem_we) begin
      mem[set_q] <= wr_row;
    end
  end

  sacl_pick #(
    .MAX_WAYS(MAX_WAYS)
  ) u_pick (
    .row      (rd_row),
    .tag      (tag_q),
    .ways_used(ways_used),
    .outcome  (pick_outcome),
    .way      (pick_way)
  );

  // ---------------- update ----------------
  always_comb begin
    // a modify restamps the same line a second time
    if (op_q == OP_MODIFY) begin
      stamp_next = stamp_cnt + STAMP_W'(2);
    end else begin
      stamp_next = stamp_cnt + STAMP_W'(1);
    end
    line_stamp       = stamp_next;
    wr_row           = rd_row;
    wr_row[pick_way] = {1'b1, tag_q, line_stamp};
    mem_we           = finish && (op_q != OP_NONE);

    if (op_q == OP_NONE) begin
      outcome_next = OUT_IGNORED;
      hit_inc      = 2'd0;
      miss_inc     = 1'b0;
      evict_inc    = 1'b0;
    end else begin
      outcome_next = pick_outcome;
      hit_inc      = 2'((pick_outcome == OUT_HIT) ? 1 : 0) +
                     2'((op_q == OP_MODIFY) ? 1 : 0);
      miss_inc     = (pick_outcome != OUT_HIT);
      evict_inc    = (pick_outcome == OUT_EVICT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_cnt       <= '0;
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
    end else if (mem_we) begin
      stamp_cnt       <= stamp_next;
      hits_total      <= sat_add(hits_total, hit_inc);
      misses_total    <= sat_add(misses_total, {1'b0, miss_inc});
      evictions_total <= sat_add(evictions_total, {1'b0, evict_inc});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      outcome    <= outcome_next;
      second_hit <= (op_q == OP_MODIFY);
    end
  end

endmodule

@@ rtl/sacl_check.sv @@
// ----------------------------------------------------------------------------
// sacl_check
// Port-level checks for the cache model, bound to the top level.
// ----------------------------------------------------------------------------
module sacl_check
  import sacl_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       outcome,
  input logic             second_hit,
  input logic [CNT_W-1:0] hits_total,
  input logic [CNT_W-1:0] misses_total,
  input logic [CNT_W-1:0] evictions_total
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(outcome) &&
      $stable(second_hit) && $stable(hits_total))
    else $error("result changed while stalled");

  // an ignored operation never reports a second access
  a_ignored: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_IGNORED |-> !second_hit)
    else $error("second hit on ignored operation");

  // every eviction is also counted as a miss
  a_evict_le_miss: assert property (@(posedge clk) disable iff (rst)
    evictions_total <= misses_total)
    else $error("evictions exceed misses");

  // hit and miss totals only grow
  a_hits_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hits_total >= $past(hits_total) &&
      misses_total >= $past(misses_total))
    else $error("total went backwards");

endmodule

bind set_assoc_lru_cache_sim sacl_check u_sacl_check (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .outcome        (outcome),
  .second_hit     (second_hit),
  .hits_total     (hits_total),
  .misses_total   (misses_total),
  .evictions_total(evictions_total)
);
